// ===== src/crrp_pkg.sv =====
// ----------------------------------------------------------------------------
// CIGAR reference range parser - shared definitions
// Character codes, status codes, register map and the record types passed
// between the front end, the result queue and the output stage.
// ----------------------------------------------------------------------------
package crrp_pkg;

    localparam int COORD_BITS_DEFAULT = 31;
    localparam int FIELD_BITS         = 31;
    localparam int STATUS_BITS        = 3;
    localparam int QUEUE_DEPTH        = 4;

    // CIGAR characters
    localparam logic [7:0] CH_0 = 8'h30;
    localparam logic [7:0] CH_9 = 8'h39;
    localparam logic [7:0] CH_M = 8'h4D;
    localparam logic [7:0] CH_I = 8'h49;
    localparam logic [7:0] CH_D = 8'h44;
    localparam logic [7:0] CH_N = 8'h4E;
    localparam logic [7:0] CH_S = 8'h53;
    localparam logic [7:0] CH_H = 8'h48;
    localparam logic [7:0] CH_P = 8'h50;

    // Read status
    localparam logic [STATUS_BITS-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_BAD_LENGTH = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_UNEXP_END  = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_P_UNSUPP   = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_UNKNOWN_OP = 3'd4;

    // Register indexes (byte address / 4)
    localparam logic [1:0] REG_DELETIONS_AS_SKIPS = 2'd0;
    localparam logic [1:0] REG_MERGE_ADJACENT     = 2'd1;
    localparam logic [1:0] REG_COUNT_HARD_CLIPS   = 2'd2;

    // Result word kinds
    localparam logic KIND_RANGE = 1'b0;
    localparam logic KIND_DONE  = 1'b1;

    typedef struct packed {
        logic deletions_as_skips;
        logic merge_adjacent;
        logic count_hard_clips;
    } cfg_t;

    // Everything one character produces: an optional range and an optional
    // done record, emitted in that order.
    typedef struct packed {
        logic                   has_range;
        logic                   has_done;
        logic [FIELD_BITS-1:0]  range_start;
        logic [FIELD_BITS-1:0]  range_width;
        logic [FIELD_BITS-1:0]  query_width;
        logic [STATUS_BITS-1:0] status;
    } bundle_t;

endpackage

// ===== src/crrp_front.sv =====
// ----------------------------------------------------------------------------
// CIGAR reference range parser - front end
// Accepts one character per cycle unless the queue is full, keeps the
// per-read parse state and classifies each character into its records.
// ----------------------------------------------------------------------------
module crrp_front #(
    parameter int COORD_BITS = crrp_pkg::COORD_BITS_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  crrp_pkg::cfg_t                      cfg,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [7:0]                          in_ch,
    input  logic                                in_first,
    input  logic                                in_last,
    input  logic [crrp_pkg::FIELD_BITS-1:0]     in_read_pos,
    input  logic                                q_full,
    output logic                                q_push,
    output crrp_pkg::bundle_t                   q_data
);
    import crrp_pkg::*;

    localparam logic [COORD_BITS-1:0] COORD_MAX = {COORD_BITS{1'b1}};

    function automatic logic [COORD_BITS-1:0] sat_add(input logic [COORD_BITS-1:0] a,
                                                      input logic [COORD_BITS-1:0] b);
        logic [COORD_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COORD_BITS] ? COORD_MAX : s[COORD_BITS-1:0];
    endfunction

    function automatic logic [FIELD_BITS-1:0] to_field(input logic [COORD_BITS-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[FIELD_BITS-1:0];
    endfunction

    logic [COORD_BITS-1:0]  op_length_reg, op_length_next;
    logic [COORD_BITS-1:0]  ref_cursor_reg, ref_cursor_next;
    logic [COORD_BITS-1:0]  pending_width_reg, pending_width_next;
    logic [COORD_BITS-1:0]  query_total_reg, query_total_next;
    logic [STATUS_BITS-1:0] error_code_reg, error_code_next;

    logic [COORD_BITS-1:0]  op_b, cur_b, pend_b, qt_b;
    logic [STATUS_BITS-1:0] err_b;
    logic [63:0]            pos64;
    logic [COORD_BITS-1:0]  pos_sat;
    logic [COORD_BITS+3:0]  op_x10;
    logic [COORD_BITS-1:0]  op_digit;
    logic [COORD_BITS-1:0]  pend_len, cur_adv, qt_add;
    logic                   digit, range_op, skip_op, emit_range;
    logic [COORD_BITS-1:0]  emit_width;
    logic                   accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb begin
        pos64   = 64'(in_read_pos);
        pos_sat = (pos64 > 64'(COORD_MAX)) ? COORD_MAX : pos64[COORD_BITS-1:0];

        // A first character starts from a clean read
        if (in_first) begin
            op_b   = '0;
            cur_b  = pos_sat;
            pend_b = '0;
            qt_b   = '0;
            err_b  = ST_OK;
        end else begin
            op_b   = op_length_reg;
            cur_b  = ref_cursor_reg;
            pend_b = pending_width_reg;
            qt_b   = query_total_reg;
            err_b  = error_code_reg;
        end

        digit    = in_ch inside {[CH_0:CH_9]};
        op_x10   = ({4'b0, op_b} << 3) + ({4'b0, op_b} << 1)
                 + (COORD_BITS+4)'(in_ch - CH_0);
        op_digit = (op_x10 > {4'b0, COORD_MAX}) ? COORD_MAX : op_x10[COORD_BITS-1:0];
        pend_len = sat_add(pend_b, op_b);
        cur_adv  = sat_add(cur_b, pend_len);
        qt_add   = sat_add(qt_b, op_b);

        op_length_next     = op_b;
        ref_cursor_next    = cur_b;
        pending_width_next = pend_b;
        query_total_next   = qt_b;
        error_code_next    = err_b;
        range_op           = 1'b0;
        skip_op            = 1'b0;
        emit_range         = 1'b0;
        emit_width         = pend_b;

        if (err_b == ST_OK) begin
            if (digit) begin
                op_length_next = op_digit;
                if (in_last) begin
                    error_code_next = (op_digit != '0) ? ST_UNEXP_END : ST_BAD_LENGTH;
                end
            end else if (op_b == '0) begin
                error_code_next = ST_BAD_LENGTH;
            end else begin
                op_length_next = '0;
                case (in_ch)
                    CH_M: begin
                        query_total_next = qt_add;
                        range_op         = 1'b1;
                    end
                    CH_I, CH_S: begin
                        query_total_next = qt_add;
                    end
                    CH_H: begin
                        if (cfg.count_hard_clips) begin
                            query_total_next = qt_add;
                        end
                    end
                    CH_D: begin
                        if (cfg.deletions_as_skips) begin
                            skip_op = 1'b1;
                        end else begin
                            range_op = 1'b1;
                        end
                    end
                    CH_N: begin
                        skip_op = 1'b1;
                    end
                    CH_P: begin
                        error_code_next = ST_P_UNSUPP;
                    end
                    default: begin
                        error_code_next = ST_UNKNOWN_OP;
                    end
                endcase
            end
        end

        if (range_op) begin
            if (cfg.merge_adjacent) begin
                pending_width_next = pend_len;
            end else begin
                emit_range         = 1'b1;
                emit_width         = pend_len;
                ref_cursor_next    = cur_adv;
                pending_width_next = '0;
            end
        end

        if (skip_op) begin
            emit_range         = (pend_b != '0);
            emit_width         = pend_b;
            ref_cursor_next    = cur_adv;
            pending_width_next = '0;
        end

        // Flush the merged range on the last character; cursor is unchanged here
        if (in_last && error_code_next == ST_OK && pending_width_next != '0) begin
            emit_range = 1'b1;
            emit_width = pending_width_next;
        end

        q_data.has_range   = emit_range;
        q_data.has_done    = in_last;
        q_data.range_start = to_field(cur_b);
        q_data.range_width = to_field(emit_width);
        q_data.query_width = (error_code_next == ST_OK) ? to_field(query_total_next) : '0;
        q_data.status      = error_code_next;
        q_push             = accept && (emit_range || in_last);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_length_reg     <= '0;
            ref_cursor_reg    <= '0;
            pending_width_reg <= '0;
            query_total_reg   <= '0;
            error_code_reg    <= ST_OK;
        end else if (accept) begin
            op_length_reg     <= op_length_next;
            ref_cursor_reg    <= ref_cursor_next;
            pending_width_reg <= pending_width_next;
            query_total_reg   <= query_total_next;
            error_code_reg    <= error_code_next;
        end
    end

endmodule

// ===== src/crrp_queue.sv =====
// ----------------------------------------------------------------------------
// CIGAR reference range parser - result queue
// Short FIFO of result bundles between the front end and the output stage.
// ----------------------------------------------------------------------------
module crrp_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  crrp_pkg::bundle_t push_data,
    input  logic              pop,
    output crrp_pkg::bundle_t pop_data,
    output logic              full,
    output logic              empty
);
    import crrp_pkg::*;

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    bundle_t               mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic                  do_push, do_pop;

    assign full     = (count_reg == CNT_BITS'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_BITS'(do_push) - CNT_BITS'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== src/crrp_back.sv =====
// ----------------------------------------------------------------------------
// CIGAR reference range parser - output stage
// Holds one bundle and sends its range word, then its done word.
// ----------------------------------------------------------------------------
module crrp_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  crrp_pkg::bundle_t q_data,
    input  logic              q_empty,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              out_kind,
    output logic              out_last,
    output logic [crrp_pkg::FIELD_BITS-1:0]  out_range_start,
    output logic [crrp_pkg::FIELD_BITS-1:0]  out_range_width,
    output logic [crrp_pkg::FIELD_BITS-1:0]  out_query_width,
    output logic [crrp_pkg::STATUS_BITS-1:0] out_status
);
    import crrp_pkg::*;

    bundle_t cur_reg;
    logic    cur_valid_reg;
    logic    fire, finish, split;

    assign fire   = cur_valid_reg && out_ready;
    // A bundle with both words stays after its range word to send the done word
    assign split  = cur_reg.has_range && cur_reg.has_done;
    assign finish = fire && !split;
    assign q_pop  = !q_empty && (!cur_valid_reg || finish);

    always_comb begin
        out_valid = cur_valid_reg;
        if (cur_reg.has_range) begin
            out_kind        = KIND_RANGE;
            out_last        = !cur_reg.has_done;
            out_range_start = cur_reg.range_start;
            out_range_width = cur_reg.range_width;
            out_query_width = '0;
            out_status      = ST_OK;
        end else begin
            out_kind        = KIND_DONE;
            out_last        = 1'b1;
            out_range_start = '0;
            out_range_width = '0;
            out_query_width = cur_reg.query_width;
            out_status      = cur_reg.status;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_reg <= q_data;
        end else if (fire && split) begin
            cur_reg.has_range <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
        end else if (q_pop) begin
            cur_valid_reg <= 1'b1;
        end else if (finish) begin
            cur_valid_reg <= 1'b0;
        end
    end

endmodule

// ===== src/cigar_reference_range_parser.sv =====
// ----------------------------------------------------------------------------
// CIGAR reference range parser - top level
// Turns a stream of CIGAR characters into reference ranges and a done word
// per read.
// ----------------------------------------------------------------------------
// The block takes one CIGAR character per cycle on the s_ stream; a
// character is never held back by its own parse, which is combinational
// digit accumulation and saturating adds in the front end. Each result word
// is its own transfer on the m_ stream, so a character that yields both a
// range and a done word (a last character that flushes a range) is sent as
// two words. A four-entry queue of per-character results sits between the
// parser and the output register; the s_ side stalls only once that queue
// is full. Mark a read's first character with s_tuser and its final one
// with s_tlast. Every read ends in a done word (m_tuser high) carrying the
// query width and a status: 0 ok, 1 bad operation length, 2 unexpected end,
// 3 P unsupported, 4 unknown operation. After an error the rest of the read
// is dropped until the next first character. Write registers only while the
// block is idle. Internal sums saturate at 2^COORD_BITS - 1.
// ----------------------------------------------------------------------------
module cigar_reference_range_parser #(
    parameter int COORD_BITS = crrp_pkg::COORD_BITS_DEFAULT
) (
    input  logic         aclk,
    input  logic         aresetn,
    // Character stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [39:0]  s_tdata,   // [7:0] ch, [38:8] read_pos, [39] zero
    input  logic         s_tuser,   // [0] first_char
    input  logic         s_tlast,   // last_char
    // Result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,   // [30:0] range_start, [61:31] range_width,
                                    // [92:62] query_width, [95:93] status
    output logic         m_tuser,   // [0] kind
    output logic         m_tlast,   // last
    // Register port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import crrp_pkg::*;

    cfg_t    cfg_reg;
    bundle_t front_bundle;
    bundle_t queue_head;
    logic    q_push, q_pop, q_full, q_empty;
    logic    reg_write;

    logic [FIELD_BITS-1:0]  out_range_start, out_range_width, out_query_width;
    logic [STATUS_BITS-1:0] out_status;

    // ---------------- Register port ----------------
    assign pready    = 1'b1;
    assign reg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.deletions_as_skips <= 1'b0;
            cfg_reg.merge_adjacent     <= 1'b1;
            cfg_reg.count_hard_clips   <= 1'b1;
        end else if (reg_write) begin
            case (paddr[3:2])
                REG_DELETIONS_AS_SKIPS: cfg_reg.deletions_as_skips <= pwdata[0];
                REG_MERGE_ADJACENT:     cfg_reg.merge_adjacent     <= pwdata[0];
                REG_COUNT_HARD_CLIPS:   cfg_reg.count_hard_clips   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_DELETIONS_AS_SKIPS: prdata = {31'b0, cfg_reg.deletions_as_skips};
            REG_MERGE_ADJACENT:     prdata = {31'b0, cfg_reg.merge_adjacent};
            REG_COUNT_HARD_CLIPS:   prdata = {31'b0, cfg_reg.count_hard_clips};
            default:                prdata = '0;
        endcase
    end

    // ---------------- Front end: parse and classify ----------------
    crrp_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_ch       (s_tdata[7:0]),
        .in_first    (s_tuser),
        .in_last     (s_tlast),
        .in_read_pos (s_tdata[38:8]),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (front_bundle)
    );

    // ---------------- Queue between the two halves ----------------
    crrp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (front_bundle),
        .pop       (q_pop),
        .pop_data  (queue_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    // ---------------- Back end: serialize result words ----------------
    crrp_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_data          (queue_head),
        .q_empty         (q_empty),
        .q_pop           (q_pop),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_kind        (m_tuser),
        .out_last        (m_tlast),
        .out_range_start (out_range_start),
        .out_range_width (out_range_width),
        .out_query_width (out_query_width),
        .out_status      (out_status)
    );

    assign m_tdata = {out_status, out_query_width, out_range_width, out_range_start};

    // ---------------- Checks ----------------
    // The front end never pushes into a full queue
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("result queue overflow");

    // A done word always closes the character's results
    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_DONE) |-> m_tlast)
        else $error("done word without tlast");

    // A range word carries no status and no query width
    a_range_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_RANGE) |-> (out_status == ST_OK && out_query_width == '0))
        else $error("range word with status or query width");

    // An accepted last character always leaves something to send
    a_last_pushes: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |-> q_push)
        else $error("last character produced no done word");

endmodule
